// ===== hdl/pjtt_pkg.sv =====
// Package for the periodic job timer table: widths, command and result codes.
// No dependencies.
package pjtt_pkg;
  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ADDR_W = 3;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ADD = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_ACK = 2'd1;
  localparam logic [1:0] KIND_FIRE = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  localparam logic [ADDR_W-1:0] REG_MAX_JOBS = 3'd0;

  typedef struct packed {
    logic [31:0] id;
    logic [16:0] remaining;
    logic [16:0] reload;
    logic        recurring;
    logic [15:0] repeats;
  } entry_t;

  // cell operations broadcast to the whole row
  typedef enum logic [2:0] {
    OP_HOLD, OP_DEC, OP_INSERT, OP_DROP, OP_RELOAD, OP_WRITE
  } cell_op_t;

  typedef struct packed {
    cell_op_t        op;
    logic [IDX_W-1:0] pos;
    entry_t          new_entry;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] job_id;
    logic        accepted;
    logic        last;
  } result_t;

  // secs + msecs/1000 via reciprocal: floor(m*4294968/2^32) is exact for 16-bit m
  function automatic logic [16:0] reload_of(input logic [15:0] secs,
                                           input logic [15:0] msecs);
    logic [54:0] prod;
    prod = 55'(msecs) * 55'd4294968;
    reload_of = 17'(secs) + 17'(prod[47:32]);
  endfunction
endpackage

// ===== hdl/pjtt_if.sv =====
// Valid/ready channel interfaces for the timer table.
// Depends on pjtt_pkg.
interface pjtt_in_if import pjtt_pkg::*; (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] timeout_secs;
  logic [15:0] timeout_msecs;
  logic        recurring;
  logic [15:0] max_repeats;
  logic [31:0] remove_id;
  modport source (output valid, cmd, timeout_secs, timeout_msecs, recurring,
                  max_repeats, remove_id, input ready);
  modport sink (input valid, cmd, timeout_secs, timeout_msecs, recurring,
                max_repeats, remove_id, output ready);
endinterface

interface pjtt_out_if import pjtt_pkg::*; (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] job_id;
  logic        accepted;
  logic        last;
  modport source (output valid, kind, job_id, accepted, last, input ready);
  modport sink (input valid, kind, job_id, accepted, last, output ready);
endinterface

// ===== hdl/pjtt_cell.sv =====
// One table slot; takes its neighbours' contents on insert/drop shifts.
// Depends on pjtt_pkg.
module pjtt_cell import pjtt_pkg::*; (
  input  logic            clk,
  input  logic [IDX_W-1:0] my_idx,
  input  cell_ctl_t       ctl,
  input  entry_t          left,
  input  entry_t          right,
  output entry_t          q
);
  entry_t q_r, q_nxt;
  assign q = q_r;

  always_comb begin
    q_nxt = q_r;
    unique case (ctl.op)
      OP_DEC: begin
        if (q_r.remaining != 17'd0) q_nxt.remaining = q_r.remaining - 17'd1;
      end
      OP_INSERT: begin
        if (my_idx == ctl.pos) q_nxt = ctl.new_entry;
        else if (my_idx > ctl.pos) q_nxt = left;
      end
      OP_DROP: begin
        if (my_idx >= ctl.pos) q_nxt = right;
      end
      OP_RELOAD: begin
        if (my_idx == ctl.pos) begin
          q_nxt.remaining = q_r.reload;
          if (q_r.repeats != 16'd0) q_nxt.repeats = q_r.repeats - 16'd1;
        end
      end
      // overwrite in place, no shift
      OP_WRITE: begin
        if (my_idx == ctl.pos) q_nxt = ctl.new_entry;
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end
endmodule

// ===== hdl/pjtt_ctrl.sv =====
// Sequencer: walks the row one slot a cycle unless stalled, issues shifts, builds results.
// Depends on pjtt_pkg and pjtt_if.
module pjtt_ctrl import pjtt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  pjtt_in_if.sink          in_ch,
  input  logic [4:0]       max_jobs,
  input  entry_t           cells [TABLE_DEPTH],
  output cell_ctl_t        ctl,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res
);
  localparam logic [2:0] S_IDLE = 3'd0, S_DEC = 3'd1, S_SCAN = 3'd2,
                         S_FIND = 3'd3, S_EMIT = 3'd4;
  localparam logic [2:0] W_TICK = 3'd0, W_ADD = 3'd1, W_REM = 3'd2;

  logic [2:0]       state_r, state_nxt;
  logic [2:0]       work_r, work_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, ptr_r, ptr_nxt;
  logic [31:0]      idc_r, idc_nxt, key_r, key_nxt;
  entry_t           new_r, new_nxt;
  logic             rv_r, rv_nxt;
  result_t          res_r, res_nxt;
  logic [CNT_W-1:0] limit;
  entry_t           cur;
  logic             in_range;

  assign limit = (max_jobs > 5'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(max_jobs);
  assign in_range = (ptr_r < count_r);
  assign cur = cells[ptr_r[IDX_W-1:0]];
  assign in_ch.ready = (state_r == S_IDLE) && !rv_r;
  assign res_valid = rv_r;
  assign res = res_r;

  always_comb begin
    state_nxt = state_r; work_nxt = work_r; count_nxt = count_r; ptr_nxt = ptr_r;
    idc_nxt = idc_r; key_nxt = key_r; new_nxt = new_r; rv_nxt = rv_r; res_nxt = res_r;
    ctl = '{op: OP_HOLD, pos: ptr_r[IDX_W-1:0], new_entry: new_r};
    if (rv_r && res_ready) rv_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          ptr_nxt = '0;
          priority case (in_ch.cmd)
            CMD_TICK: begin work_nxt = W_TICK; state_nxt = S_DEC; end
            CMD_ADD: begin
              if (count_r >= limit) begin
                rv_nxt = 1'b1;
                res_nxt = '{kind: KIND_ADD, job_id: 32'd0, accepted: 1'b0, last: 1'b1};
              end else begin
                work_nxt = W_ADD; state_nxt = S_FIND;
                idc_nxt = idc_r + 32'd1; key_nxt = idc_r + 32'd1;
                new_nxt.id = idc_r + 32'd1;
                new_nxt.reload = reload_of(in_ch.timeout_secs, in_ch.timeout_msecs);
                new_nxt.remaining = reload_of(in_ch.timeout_secs, in_ch.timeout_msecs);
                new_nxt.recurring = in_ch.recurring;
                new_nxt.repeats = in_ch.max_repeats;
              end
            end
            CMD_REMOVE: begin
              work_nxt = W_REM; state_nxt = S_FIND; key_nxt = in_ch.remove_id;
            end
            default: ;
          endcase
        end
      end
      S_DEC: begin
        ctl.op = OP_DEC; state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (!rv_r || res_ready) begin
          if (!in_range) begin
            rv_nxt = 1'b1;
            res_nxt = '{kind: KIND_DONE, job_id: 32'd0, accepted: 1'b0, last: 1'b1};
            state_nxt = S_IDLE;
          end else if (cur.remaining != 17'd0) begin
            ptr_nxt = ptr_r + CNT_W'(1);
          end else begin
            rv_nxt = 1'b1;
            res_nxt = '{kind: KIND_FIRE, job_id: cur.id, accepted: 1'b0, last: 1'b0};
            if (cur.recurring && (cur.repeats != 16'd1)) begin
              ctl.op = OP_RELOAD; ptr_nxt = ptr_r + CNT_W'(1);
            end else begin
              ctl.op = OP_DROP; count_nxt = count_r - CNT_W'(1);
            end
          end
        end
      end
      S_FIND: begin
        if (work_r == W_ADD) begin
          if (in_range && cur.id < key_r) ptr_nxt = ptr_r + CNT_W'(1);
          else begin
            // id counter wrapped onto a live entry: replace it in place
            if (in_range && cur.id == key_r) ctl.op = OP_WRITE;
            else begin
              ctl.op = OP_INSERT; count_nxt = count_r + CNT_W'(1);
            end
            state_nxt = S_EMIT;
          end
        end else begin
          if (!in_range) state_nxt = S_EMIT;
          else if (cur.id == key_r) begin
            ctl.op = OP_DROP; count_nxt = count_r - CNT_W'(1); state_nxt = S_EMIT;
          end else ptr_nxt = ptr_r + CNT_W'(1);
        end
      end
      S_EMIT: begin
        rv_nxt = 1'b1; state_nxt = S_IDLE;
        if (work_r == W_ADD)
          res_nxt = '{kind: KIND_ADD, job_id: key_r, accepted: 1'b1, last: 1'b1};
        else
          res_nxt = '{kind: KIND_ACK, job_id: 32'd0, accepted: 1'b1, last: 1'b1};
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; count_r <= '0; idc_r <= '0; rv_r <= 1'b0;
      work_r <= W_TICK; ptr_r <= '0;
    end else begin
      state_r <= state_nxt; count_r <= count_nxt; idc_r <= idc_nxt; rv_r <= rv_nxt;
      work_r <= work_nxt; ptr_r <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt; new_r <= new_nxt; res_r <= res_nxt;
  end
endmodule

// ===== hdl/periodic_job_timer_table_top.sv =====
// Top level of the timer table: APB register, sequencer and row of cells.
// Depends on pjtt_pkg, pjtt_if, pjtt_cell, pjtt_ctrl.
//
//  channel | dir | handshake        | payload
//  in_ch   | in  | valid/ready      | cmd, timeouts, recurring, max_repeats, remove_id
//  out_ch  | out | valid/ready      | kind, job_id, accepted, last
//  cfg     | in  | APB, pready = 1  | max_jobs at byte address 0
//
// Add: scans the entries below the new id; remove: scans until the id is found or the end.
// Tick: decrements all entries, then visits each, each fire waiting for its result beat to be taken.
// The sequencer visits one cell a cycle unless stalled; a shift moves the whole row at once.
// Reset clears count and id counter; table contents are not cleared.
// Output stalls hold the scan; a new item is taken once the last beat has left.
module periodic_job_timer_table_top import pjtt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  pjtt_in_if.sink           in_ch,
  pjtt_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  logic [4:0] max_jobs_r;
  cell_ctl_t  ctl;
  entry_t     cells [TABLE_DEPTH];
  result_t    res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_MAX_JOBS) ? {27'd0, max_jobs_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) max_jobs_r <= 5'd16;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_MAX_JOBS)
      max_jobs_r <= cfg_pwdata[4:0];
  end

  pjtt_ctrl u_ctrl (
    .clk, .rst_n, .in_ch, .max_jobs(max_jobs_r), .cells, .ctl,
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res
  );

  assign out_ch.kind = res.kind;
  assign out_ch.job_id = res.job_id;
  assign out_ch.accepted = res.accepted;
  assign out_ch.last = res.last;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    pjtt_cell u_cell (
      .clk, .my_idx(IDX_W'(g)), .ctl,
      .left(cells[(g == 0) ? 0 : g - 1]),
      .right(cells[(g == TABLE_DEPTH - 1) ? g : g + 1]),
      .q(cells[g])
    );
  end
endmodule

// ===== hdl/pjtt_checker.sv =====
// Port-level checks for the timer table, bound to the top level.
// Depends on pjtt_pkg.
module pjtt_checker import pjtt_pkg::*; (
  input logic clk, rst_n,
  input logic in_ready, out_valid, out_ready, out_last,
  input logic [1:0] out_kind, input logic [31:0] out_job_id
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_job_id)) else $error("beat dropped");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DONE |-> out_last) else $error("done not last");
  a_fire_notlast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_FIRE |-> !out_last) else $error("fire marked last");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> !in_ready) else $error("took item mid-tick");
endmodule

bind periodic_job_timer_table_top pjtt_checker u_chk (
  .clk, .rst_n, .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.last),
  .out_kind(out_ch.kind), .out_job_id(out_ch.job_id)
);

// ===== tb/sv/periodic_job_timer_table_top_test.sv =====
// Testbench for periodic_job_timer_table_top: a directed table, then random
// phases over several max_jobs settings, checked against table rows and a local predictor.
// Depends on pjtt_pkg, pjtt_if and the timer table RTL.
`timescale 1ns / 100ps

module periodic_job_timer_table_top_test;
  import pjtt_pkg::*;

  typedef struct {
    logic [1:0]  cmd;
    logic [15:0] secs;
    logic [15:0] msecs;
    logic        rec;
    logic [15:0] reps;
    logic [31:0] rid;
  } timer_cmd_t;

  typedef struct {
    timer_cmd_t c;
    bit         typed;
    result_t    want;
  } table_row_t;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pjtt_in_if  in_ch (clk);
  pjtt_out_if out_ch (clk);

  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  periodic_job_timer_table_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // timer table as the block should hold it
  logic [31:0] tmr_id [TABLE_DEPTH];
  logic [16:0] tmr_left [TABLE_DEPTH];
  logic [16:0] tmr_reload [TABLE_DEPTH];
  logic        tmr_rec [TABLE_DEPTH];
  logic [15:0] tmr_reps [TABLE_DEPTH];
  int          tmr_count = 0;
  logic [31:0] next_id = '0;
  logic [4:0]  job_cap = 5'd16;

  result_t beats_due[$];
  int      mismatches = 0;
  int      send_idle_pct = 34;
  int      recv_idle_pct = 61;
  int      stall_req = 0;

  function automatic result_t mk_beat(logic [1:0] kind, logic [31:0] id, logic acc,
                                      logic last);
    result_t r;
    r.kind = kind;
    r.job_id = id;
    r.accepted = acc;
    r.last = last;
    return r;
  endfunction

  function automatic void drop_timer(int pos);
    for (int j = pos; j + 1 < tmr_count; j++) begin
      tmr_id[j] = tmr_id[j+1];
      tmr_left[j] = tmr_left[j+1];
      tmr_reload[j] = tmr_reload[j+1];
      tmr_rec[j] = tmr_rec[j+1];
      tmr_reps[j] = tmr_reps[j+1];
    end
    tmr_count--;
  endfunction

  // advance the table by one command; beats are queued unless the row gives them
  function automatic void apply_timer_cmd(timer_cmd_t c, bit queue_beats);
    int i;
    int pos;
    int cap;
    bit keep;
    result_t outs[$];
    case (c.cmd)
      CMD_TICK: begin
        i = 0;
        while (i < tmr_count) begin
          if (tmr_left[i] != 0) tmr_left[i]--;
          if (tmr_left[i] != 0) begin
            i++;
            continue;
          end
          outs.push_back(mk_beat(KIND_FIRE, tmr_id[i], 1'b0, 1'b0));
          if (!tmr_rec[i]) keep = 1'b0;
          else if (tmr_reps[i] == 0) keep = 1'b1;
          else begin
            tmr_reps[i]--;
            keep = (tmr_reps[i] != 0);
          end
          if (keep) begin
            tmr_left[i] = tmr_reload[i];
            i++;
          end else begin
            drop_timer(i);
          end
        end
        outs.push_back(mk_beat(KIND_DONE, '0, 1'b0, 1'b1));
      end
      CMD_ADD: begin
        cap = (job_cap < TABLE_DEPTH) ? job_cap : TABLE_DEPTH;
        if (tmr_count >= cap) begin
          outs.push_back(mk_beat(KIND_ADD, '0, 1'b0, 1'b1));
        end else begin
          next_id++;
          pos = 0;
          while (pos < tmr_count && tmr_id[pos] < next_id) pos++;
          if (!(pos < tmr_count && tmr_id[pos] == next_id)) begin
            for (int j = tmr_count; j > pos; j--) begin
              tmr_id[j] = tmr_id[j-1];
              tmr_left[j] = tmr_left[j-1];
              tmr_reload[j] = tmr_reload[j-1];
              tmr_rec[j] = tmr_rec[j-1];
              tmr_reps[j] = tmr_reps[j-1];
            end
            tmr_count++;
          end
          tmr_id[pos] = next_id;
          tmr_reload[pos] = 17'(c.secs) + 17'(c.msecs / 16'd1000);
          tmr_left[pos] = tmr_reload[pos];
          tmr_rec[pos] = c.rec;
          tmr_reps[pos] = c.reps;
          outs.push_back(mk_beat(KIND_ADD, next_id, 1'b1, 1'b1));
        end
      end
      CMD_REMOVE: begin
        for (int j = 0; j < tmr_count; j++) begin
          if (tmr_id[j] == c.rid) begin
            drop_timer(j);
            break;
          end
        end
        outs.push_back(mk_beat(KIND_ACK, '0, 1'b1, 1'b1));
      end
      default: ;
    endcase
    if (queue_beats) foreach (outs[k]) beats_due.push_back(outs[k]);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // offer one beat after a random gap; valid stays high on return
  task automatic send_cmd(timer_cmd_t c, bit typed, result_t want);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c.cmd;
    in_ch.timeout_secs <= c.secs;
    in_ch.timeout_msecs <= c.msecs;
    in_ch.recurring <= c.rec;
    in_ch.max_repeats <= c.reps;
    in_ch.remove_id <= c.rid;
    do @(posedge clk); while (!in_ch.ready);
    apply_timer_cmd(c, !typed);
    if (typed) beats_due.push_back(want);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_jobs(logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_MAX_JOBS;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    job_cap = value[4:0];
  endtask

  function automatic timer_cmd_t tcmd(logic [1:0] cmd, logic [15:0] secs, logic [15:0] msecs,
                                      logic rec, logic [15:0] reps, logic [31:0] rid);
    timer_cmd_t c;
    c.cmd = cmd;
    c.secs = secs;
    c.msecs = msecs;
    c.rec = rec;
    c.reps = reps;
    c.rid = rid;
    return c;
  endfunction

  function automatic timer_cmd_t random_cmd(int add_pct);
    timer_cmd_t c;
    int roll;
    roll = $urandom_range(99);
    c.cmd = (roll < add_pct) ? CMD_ADD :
            (roll < add_pct + 20) ? CMD_REMOVE :
            (roll < 96) ? CMD_TICK : CMD_UNUSED;
    c.secs = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    c.msecs = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(2999));
    c.rec = $urandom_range(1);
    c.reps = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    if (tmr_count > 0 && $urandom_range(4) != 0)
      c.rid = tmr_id[$urandom_range(tmr_count - 1)];
    else
      c.rid = $urandom;
    return c;
  endfunction

  // result side: check each beat, idle at random, honour a requested long stall
  always @(posedge clk) begin
    result_t w;
    int stall_left;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (beats_due.size() == 0) begin
        report_mismatch("unexpected beat, job_id", out_ch.job_id, '0);
      end else begin
        w = beats_due.pop_front();
        if (out_ch.kind !== w.kind) report_mismatch("kind", out_ch.kind, w.kind);
        if (out_ch.job_id !== w.job_id) report_mismatch("job_id", out_ch.job_id, w.job_id);
        if (out_ch.accepted !== w.accepted)
          report_mismatch("accepted", out_ch.accepted, w.accepted);
        if (out_ch.last !== w.last) report_mismatch("last", out_ch.last, w.last);
      end
    end
    if (stall_req > 0) begin
      stall_left = stall_req;
      stall_req = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: cycles with no beat moving on either channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("periodic_job_timer_table_top regression: fail");
      $finish;
    end
  end

  initial begin
    table_row_t rows[$];
    table_row_t r;
    int cap_list[5];
    int len_list[5];
    int add_list[5];
    result_t none;
    none = mk_beat(KIND_DONE, '0, 1'b0, 1'b1);
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_TICK;
    in_ch.timeout_secs = '0;
    in_ch.timeout_msecs = '0;
    in_ch.recurring = 1'b0;
    in_ch.max_repeats = '0;
    in_ch.remove_id = '0;
    out_ch.ready = 1'b0;

    r.typed = 1'b1;
    r.c = tcmd(CMD_TICK, 0, 0, 0, 0, 0);              r.want = none;
    rows.push_back(r);
    // zero reload: fires on the very next tick
    r.c = tcmd(CMD_ADD, 0, 0, 0, 0, 0);               r.want = mk_beat(KIND_ADD, 1, 1, 1);
    rows.push_back(r);
    r.typed = 1'b0; r.c = tcmd(CMD_TICK, 0, 0, 0, 0, 0); rows.push_back(r);
    r.typed = 1'b1;
    r.c = tcmd(CMD_ADD, 0, 16'hFFFF, 1, 2, 0);        r.want = mk_beat(KIND_ADD, 2, 1, 1);
    rows.push_back(r);
    r.c = tcmd(CMD_ADD, 16'hFFFF, 16'hFFFF, 1, 0, 0); r.want = mk_beat(KIND_ADD, 3, 1, 1);
    rows.push_back(r);
    r.c = tcmd(CMD_ADD, 1, 999, 1, 16'hFFFF, 0);      r.want = mk_beat(KIND_ADD, 4, 1, 1);
    rows.push_back(r);
    r.c = tcmd(CMD_ADD, 2, 1000, 0, 0, 0);            r.want = mk_beat(KIND_ADD, 5, 1, 1);
    rows.push_back(r);
    r.c = tcmd(CMD_ADD, 1, 0, 1, 1, 0);               r.want = mk_beat(KIND_ADD, 6, 1, 1);
    rows.push_back(r);
    r.typed = 1'b0;
    repeat (4) begin
      r.c = tcmd(CMD_TICK, 0, 0, 0, 0, 0);
      rows.push_back(r);
    end
    r.typed = 1'b1;
    r.c = tcmd(CMD_REMOVE, 0, 0, 0, 0, 3);            r.want = mk_beat(KIND_ACK, 0, 1, 1);
    rows.push_back(r);
    // unknown id still acknowledged
    r.c = tcmd(CMD_REMOVE, 0, 0, 0, 0, 32'hFFFF_FFFF); r.want = mk_beat(KIND_ACK, 0, 1, 1);
    rows.push_back(r);
    // command 3 is dropped silently
    r.typed = 1'b0;
    r.c = tcmd(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 32'hFFFF_FFFF);
    rows.push_back(r);
    r.c = tcmd(CMD_ADD, 3, 65, 1, 3, 0); rows.push_back(r);
    r.c = tcmd(CMD_REMOVE, 0, 0, 0, 0, 2); rows.push_back(r);
    r.c = tcmd(CMD_TICK, 0, 0, 0, 0, 0); rows.push_back(r);
    r.c = tcmd(CMD_TICK, 0, 0, 0, 0, 0); rows.push_back(r);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[n]) send_cmd(rows[n].c, rows[n].typed, rows[n].want);

    // max_jobs of zero rejects every add
    wait_drained();
    write_max_jobs(0);
    send_cmd(tcmd(CMD_ADD, 5, 0, 0, 0, 0), 1'b1, mk_beat(KIND_ADD, 0, 0, 1));
    send_cmd(tcmd(CMD_TICK, 0, 0, 0, 0, 0), 1'b0, none);

    cap_list = '{3, 31, 1, 16, 8};
    len_list = '{18, 25, 12, 30, 15};
    add_list = '{40, 65, 40, 55, 35};
    foreach (cap_list[p]) begin
      wait_drained();
      if (p == 2) begin
        send_idle_pct = 61;
        recv_idle_pct = 34;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_max_jobs(cap_list[p]);
      if (p == 3) stall_req = 300;
      repeat (len_list[p]) send_cmd(random_cmd(add_list[p]), 1'b0, none);
    end

    in_ch.valid <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("periodic_job_timer_table_top regression: pass");
    else
      $display("periodic_job_timer_table_top regression: fail");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/pjtt_pkg.sv
hdl/pjtt_if.sv
hdl/pjtt_cell.sv
hdl/pjtt_ctrl.sv
hdl/periodic_job_timer_table_top.sv
hdl/pjtt_checker.sv
tb/sv/periodic_job_timer_table_top_test.sv
